// ===== hdl/xtd_pkg.sv =====
// shared types and constants for the xml text entity decoder
// no dependencies; used by xtd_collect, xtd_resolve and the core

package xtd_pkg;

  // input modes
  localparam logic [1:0] MODE_TEXT   = 2'd0;
  localparam logic [1:0] MODE_END    = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;
  localparam logic [1:0] MODE_IGNORE = 2'd3;

  // sticky error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_UNTERM  = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN = 3'd2;
  localparam logic [2:0] ERR_BADREF  = 3'd3;
  localparam logic [2:0] ERR_TOOLONG = 3'd4;

  // characters with a role in reference parsing
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;

  // code point limits
  localparam logic [20:0] CP_MAX = 21'h10FFFF;

  // status width on the result port
  localparam int STAT_W = 24;
  localparam logic [23:0] MAX_ITEM_RESET = 24'd32767;

  // reference collection state
  typedef struct packed {
    logic        in_entity;
    logic [31:0] name_bytes;
    logic [2:0]  name_count;
    logic        is_numeric;
    logic        is_hex;
    logic        digits_seen;
    logic        bad_ref;
    logic [20:0] code_value;
  } ent_t;

  // resolved reference: byte count 0..4, first byte in the top lane
  typedef struct packed {
    logic [2:0]  count;
    logic [31:0] bytes;
    logic [2:0]  err;
  } res_t;

endpackage

// ===== hdl/xtd_collect.sv =====
// next reference state for one body byte of a reference
// depends on xtd_pkg (ent_t, CH_HASH, CP_MAX)

module xtd_collect (
  input  xtd_pkg::ent_t cur,
  input  logic [7:0]    ch,
  output xtd_pkg::ent_t nxt
);

  logic [2:0]  pos;
  logic        is_x;
  logic        dig_ok;
  logic [3:0]  dig_val;
  logic [24:0] prod;
  logic [24:0] acc_val;

  assign pos  = cur.name_count;
  assign is_x = (ch == 8'h78) || (ch == 8'h58);

  // digit value and whether it fits the base
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      dig_ok  = 1'b1;
      dig_val = 4'(ch - 8'h30);
    end else if (cur.is_hex && ch >= 8'h61 && ch <= 8'h66) begin
      dig_ok  = 1'b1;
      dig_val = 4'(ch - 8'h57);
    end else if (cur.is_hex && ch >= 8'h41 && ch <= 8'h46) begin
      dig_ok  = 1'b1;
      dig_val = 4'(ch - 8'h37);
    end
  end

  // times 16 is a shift, times 10 is two shifts and an add
  assign prod = cur.is_hex ? {cur.code_value, 4'b0000}
                           : ({1'b0, cur.code_value, 3'b000} + {3'b000, cur.code_value, 1'b0});
  assign acc_val = prod + {21'd0, dig_val};

  always_comb begin
    nxt = cur;
    if (pos != 3'd7) begin
      nxt.name_count = pos + 3'd1;
    end
    priority if (pos == 3'd0 && ch == xtd_pkg::CH_HASH) begin
      nxt.is_numeric = 1'b1;
    end else if (cur.is_numeric) begin
      if (pos == 3'd1 && is_x && !cur.is_hex) begin
        nxt.is_hex = 1'b1;
      end else begin
        nxt.digits_seen = 1'b1;
        if (!cur.bad_ref) begin
          if (!dig_ok || acc_val > {4'd0, xtd_pkg::CP_MAX}) begin
            nxt.bad_ref = 1'b1;
          end else begin
            nxt.code_value = acc_val[20:0];
          end
        end
      end
    end else begin
      nxt.name_bytes = {cur.name_bytes[23:0], ch};
    end
  end

endmodule

// ===== hdl/xtd_resolve.sv =====
// resolves a finished reference into up to four utf-8 bytes or an error
// depends on xtd_pkg (ent_t, res_t, error codes)

module xtd_resolve (
  input  xtd_pkg::ent_t ent,
  output xtd_pkg::res_t res
);

  localparam logic [31:0] NAME_AMP  = 32'h00616D70;
  localparam logic [31:0] NAME_LT   = 32'h00006C74;
  localparam logic [31:0] NAME_GT   = 32'h00006774;
  localparam logic [31:0] NAME_QUOT = 32'h71756F74;
  localparam logic [31:0] NAME_APOS = 32'h61706F73;

  logic [20:0] c;
  logic        char_ok;

  assign c = ent.code_value;

  // xml char ranges
  assign char_ok = (c == 21'h09) || (c == 21'h0A) || (c == 21'h0D)
                || (c >= 21'h20 && c <= 21'hD7FF)
                || (c >= 21'hE000 && c <= 21'hFFFD)
                || (c >= 21'h10000 && c <= xtd_pkg::CP_MAX);

  always_comb begin
    res.count = 3'd0;
    res.bytes = 32'd0;
    res.err   = xtd_pkg::ERR_NONE;
    if (ent.is_numeric) begin
      priority if (ent.name_count < 3'd2) begin
        res.err = xtd_pkg::ERR_UNKNOWN;
      end else if (!ent.digits_seen || ent.bad_ref || !char_ok) begin
        res.err = xtd_pkg::ERR_BADREF;
      end else if (c <= 21'h7F) begin
        res.count = 3'd1;
        res.bytes = {1'b0, c[6:0], 24'd0};
      end else if (c <= 21'h7FF) begin
        res.count = 3'd2;
        res.bytes = {3'b110, c[10:6], 2'b10, c[5:0], 16'd0};
      end else if (c <= 21'hFFFF) begin
        res.count = 3'd3;
        res.bytes = {4'b1110, c[15:12], 2'b10, c[11:6], 2'b10, c[5:0], 8'd0};
      end else begin
        res.count = 3'd4;
        res.bytes = {5'b11110, c[20:18], 2'b10, c[17:12], 2'b10, c[11:6], 2'b10, c[5:0]};
      end
    end else begin
      priority if (ent.name_count == 3'd3 && ent.name_bytes == NAME_AMP) begin
        res.count = 3'd1;
        res.bytes = {8'h26, 24'd0};
      end else if (ent.name_count == 3'd2 && ent.name_bytes == NAME_LT) begin
        res.count = 3'd1;
        res.bytes = {8'h3C, 24'd0};
      end else if (ent.name_count == 3'd2 && ent.name_bytes == NAME_GT) begin
        res.count = 3'd1;
        res.bytes = {8'h3E, 24'd0};
      end else if (ent.name_count == 3'd4 && ent.name_bytes == NAME_QUOT) begin
        res.count = 3'd1;
        res.bytes = {8'h22, 24'd0};
      end else if (ent.name_count == 3'd4 && ent.name_bytes == NAME_APOS) begin
        res.count = 3'd1;
        res.bytes = {8'h27, 24'd0};
      end else begin
        res.err = xtd_pkg::ERR_UNKNOWN;
      end
    end
  end

endmodule

// ===== hdl/xml_text_entity_decoder_core.sv =====
// xml text entity decoder top level: byte stream in, decoded utf-8 words out
// depends on xtd_pkg, xtd_collect and xtd_resolve
//
// usage:
//   input channel: one word per text byte (in_mode 0), end of text segment
//   (in_mode 1) or start of a new item (in_mode 2); taken when in_valid is
//   high and in_stall is low
//   result channel: every input word gives one to four result words; the
//   final one carries out_last; out_has_byte marks words that hold a byte
//   cfg_wr_en/cfg_wr_data load max_item_bytes; the user writes it only
//   while the block is idle, which the block itself does not enforce
// latency: a result word is on the output the cycle after its input is taken
// throughput: one input word per cycle when each gives a single result and
//   out_stall is low; a word that closes a character reference holds the
//   input while the single output word register drains the encoded bytes
// stall: the output register holds while out_stall is high; a new input is
//   taken in the same cycle the last word of the previous one leaves
// reset: max_item_bytes returns to 32767, lengths, errors and reference
//   state clear, the output register empties

module xml_text_entity_decoder_core #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic [1:0]  in_mode,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic        out_last,
  output logic [2:0]  out_error,
  output logic [23:0] out_item_length,
  output logic [23:0] out_peak_length
);

  // common width for comparing lengths to the 24-bit limit and port
  localparam int CW = (LENGTH_BITS > xtd_pkg::STAT_W) ? LENGTH_BITS : xtd_pkg::STAT_W;
  localparam logic [LENGTH_BITS-1:0] LEN_CAP = {LENGTH_BITS{1'b1}};

  // architectural state
  logic [23:0]            max_r;
  xtd_pkg::ent_t          ent_r, ent_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LENGTH_BITS-1:0] peak_r, peak_nxt;
  logic [2:0]             err_r, err_nxt;

  // output word register
  logic        ovld_r, ovld_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic        has_r, has_nxt;
  logic [31:0] obytes_r, obytes_nxt;

  // step results
  xtd_pkg::ent_t          col_ent;
  xtd_pkg::res_t          res;
  logic [2:0]             n_step;
  logic [31:0]            bytes_step;
  logic [LENGTH_BITS:0]   len_sum;
  logic [LENGTH_BITS-1:0] len_sat;
  logic [CW-1:0]          len_cmp;
  logic [CW-1:0]          max_cmp;
  logic [CW-1:0]          len_ext;
  logic [CW-1:0]          peak_ext;
  logic                   acc;
  logic                   take;

  xtd_collect u_collect (
    .cur (ent_r),
    .ch  (in_text_byte),
    .nxt (col_ent)
  );

  xtd_resolve u_resolve (
    .ent (ent_r),
    .res (res)
  );

  // handshake: free when empty or when the last word leaves now
  assign take     = ovld_r && !out_stall;
  assign in_stall = ovld_r && (out_stall || rem_r != 3'd1);
  assign acc      = in_valid && !in_stall;

  // length bump for the bytes of this step, saturating
  assign len_sum = {1'b0, len_r} + (LENGTH_BITS + 1)'(n_step);
  assign len_sat = len_sum[LENGTH_BITS] ? LEN_CAP : len_sum[LENGTH_BITS-1:0];
  assign len_cmp = CW'(len_sat);
  assign max_cmp = CW'(max_r);

  // one input word worth of decoding
  always_comb begin
    ent_nxt    = ent_r;
    len_nxt    = len_r;
    peak_nxt   = peak_r;
    err_nxt    = err_r;
    n_step     = 3'd0;
    bytes_step = 32'd0;
    if (acc) begin
      unique case (in_mode)
        xtd_pkg::MODE_START: begin
          ent_nxt = '0;
          len_nxt = '0;
          err_nxt = xtd_pkg::ERR_NONE;
        end
        xtd_pkg::MODE_END: begin
          if (err_r == xtd_pkg::ERR_NONE) begin
            if (ent_r.in_entity) begin
              err_nxt = xtd_pkg::ERR_UNTERM;
            end else if (len_r > peak_r) begin
              peak_nxt = len_r;
            end
          end
          ent_nxt = '0;
        end
        xtd_pkg::MODE_TEXT: begin
          // pending error blocks text until the next item start
          if (err_r == xtd_pkg::ERR_NONE) begin
            priority if (!ent_r.in_entity) begin
              if (in_text_byte == xtd_pkg::CH_AMP) begin
                ent_nxt           = '0;
                ent_nxt.in_entity = 1'b1;
              end else begin
                n_step     = 3'd1;
                bytes_step = {in_text_byte, 24'd0};
              end
            end else if (in_text_byte != xtd_pkg::CH_SEMI) begin
              ent_nxt = col_ent;
            end else begin
              n_step     = res.count;
              bytes_step = res.bytes;
              ent_nxt    = '0;
              if (res.err != xtd_pkg::ERR_NONE) begin
                err_nxt = res.err;
              end
            end
            if (n_step != 3'd0) begin
              len_nxt = len_sat;
              if (len_cmp > max_cmp) begin
                err_nxt = xtd_pkg::ERR_TOOLONG;
              end
            end
          end
        end
        default: begin
          // unused mode: status word only
        end
      endcase
    end
  end

  // output register: load on accept, drain one byte per taken word
  always_comb begin
    ovld_nxt   = ovld_r;
    rem_nxt    = rem_r;
    has_nxt    = has_r;
    obytes_nxt = obytes_r;
    if (acc) begin
      ovld_nxt   = 1'b1;
      rem_nxt    = (n_step == 3'd0) ? 3'd1 : n_step;
      has_nxt    = (n_step != 3'd0);
      obytes_nxt = bytes_step;
    end else if (take) begin
      if (rem_r == 3'd1) begin
        ovld_nxt = 1'b0;
      end else begin
        rem_nxt    = rem_r - 3'd1;
        obytes_nxt = {obytes_r[23:0], 8'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= xtd_pkg::MAX_ITEM_RESET;
      ent_r  <= '0;
      len_r  <= '0;
      peak_r <= '0;
      err_r  <= xtd_pkg::ERR_NONE;
      ovld_r <= 1'b0;
      rem_r  <= 3'd1;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      ent_r  <= ent_nxt;
      len_r  <= len_nxt;
      peak_r <= peak_nxt;
      err_r  <= err_nxt;
      ovld_r <= ovld_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    has_r    <= has_nxt;
    obytes_r <= obytes_nxt;
  end

  // status follows the state after the step on show; the state only moves
  // when the last word of that step leaves
  assign len_ext  = CW'(len_r);
  assign peak_ext = CW'(peak_r);

  assign out_valid       = ovld_r;
  assign out_byte        = obytes_r[31:24];
  assign out_has_byte    = has_r;
  assign out_last        = (rem_r == 3'd1);
  assign out_error       = err_r;
  assign out_item_length = len_ext[23:0];
  assign out_peak_length = peak_ext[23:0];

endmodule
